// ----- src/hsv_red_mask_band_counter_core_macros.svh -----
// Assertion macros for the HSV red mask band counter.
// Used by the top level; expects clk and rst_n in the scope of use.
`ifndef HSV_RED_MASK_BAND_COUNTER_CORE_MACROS_SVH
`define HSV_RED_MASK_BAND_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSVRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsvrm assertion failed");

// Next-cycle implication, disabled during reset.
`define HSVRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsvrm assertion failed");

`endif

// ----- src/hsvrm_pkg.sv -----
// Shared types and constants of the HSV red mask band counter.
// No dependencies; imported by the interfaces and all modules.
package hsvrm_pkg;

  localparam int CH_W       = 8;
  localparam int COL_W      = 5;
  localparam int ROW_W      = 4;
  localparam int HUE_W      = 9;
  localparam int PCT_W      = 7;
  localparam int HN_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int NUM_BANDS  = 5;
  localparam int BAND_IDX_W = 3;
  localparam int COUNT_W    = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW_MAX  = 3'd0,
    REG_HUE_HIGH_MIN = 3'd1,
    REG_SAT_MIN      = 3'd2,
    REG_SAT_MAX      = 3'd3,
    REG_VAL_MIN      = 3'd4,
    REG_VAL_MAX      = 3'd5
  } hsvrm_reg_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_low_max;
    logic [HUE_W-1:0] hue_high_min;
    logic [PCT_W-1:0] sat_min;
    logic [PCT_W-1:0] sat_max;
    logic [PCT_W-1:0] val_min;
    logic [PCT_W-1:0] val_max;
  } hsvrm_cfg_t;

  localparam hsvrm_cfg_t CFG_RESET = '{
    hue_low_max:  9'd60,
    hue_high_min: 9'd300,
    sat_min:      7'd10,
    sat_max:      7'd100,
    val_min:      7'd15,
    val_max:      7'd90
  };

endpackage

// ----- src/hsvrm_if.sv -----
// Valid/ready channel interfaces: pixel requests, results and register writes.
// Depends on hsvrm_pkg for field widths.
interface hsvrm_pix_if import hsvrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             frame_start;

  modport source (output valid, red, green, blue, col, row, frame_start, input ready);
  modport sink   (input valid, red, green, blue, col, row, frame_start, output ready);
endinterface

interface hsvrm_res_if import hsvrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_red;
  logic [COUNT_W-1:0] band_count_0;
  logic [COUNT_W-1:0] band_count_1;
  logic [COUNT_W-1:0] band_count_2;
  logic [COUNT_W-1:0] band_count_3;
  logic [COUNT_W-1:0] band_count_4;

  modport source (output valid, is_red, band_count_0, band_count_1, band_count_2,
                  band_count_3, band_count_4, input ready);
  modport sink   (input valid, is_red, band_count_0, band_count_1, band_count_2,
                  band_count_3, band_count_4, output ready);
endinterface

interface hsvrm_cfg_if import hsvrm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/hsvrm_classify.sv -----
// Two-step HSV window test of one pixel: hue numerator, saturation and value
// on load, hue bounds in the cycle after. Depends on hsvrm_pkg.
module hsvrm_classify import hsvrm_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  hsvrm_cfg_t       cfg,
  output logic             is_red
);

  localparam int PROD_W = 15;

  logic [CH_W-1:0]   mx, mn, d, pa, pb, dif;
  logic [HN_W-1:0]   base, sixty, hn_nxt;
  logic [PROD_W-1:0] sat_num, sat_lo, sat_hi, mx_pct, val_lo, val_hi;
  logic              grey, sat_ok, val_ok;

  logic [HN_W-1:0]   hn_r;
  logic [CH_W-1:0]   d_r;
  logic              grey_r, sv_ok_r;

  logic [HN_W-1:0]   lo_bound, hi_bound, full_turn;
  logic              hue_ok;

  always_comb begin
    mx = (red > green) ? red : green;
    mn = (red < green) ? red : green;
    if (blue > mx) mx = blue;
    if (blue < mn) mn = blue;
    d    = mx - mn;
    grey = (d == '0);

    // pick the channel pair and sector offset of the hue sector
    if (mx == red) begin
      pa   = green;
      pb   = blue;
      base = (green >= blue) ? '0 : HN_W'(d) * HN_W'(360);
    end else if (mx == green) begin
      pa   = blue;
      pb   = red;
      base = HN_W'(d) * HN_W'(120);
    end else begin
      pa   = red;
      pb   = green;
      base = HN_W'(d) * HN_W'(240);
    end
    dif    = (pa >= pb) ? pa - pb : pb - pa;
    sixty  = HN_W'(dif) * HN_W'(60);
    hn_nxt = (pa >= pb) ? base + sixty : base - sixty;

    sat_num = PROD_W'(d) * PROD_W'(100);
    sat_lo  = PROD_W'(cfg.sat_min) * PROD_W'(mx);
    sat_hi  = PROD_W'(cfg.sat_max) * PROD_W'(mx);
    sat_ok  = grey ? (cfg.sat_min == '0) : ((sat_num >= sat_lo) && (sat_num <= sat_hi));

    mx_pct = PROD_W'(mx) * PROD_W'(100);
    val_lo = {cfg.val_min, 8'd0};
    val_hi = {cfg.val_max, 8'd0};
    val_ok = (mx_pct >= val_lo) && (mx_pct <= val_hi);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hn_r    <= hn_nxt;
      d_r     <= d;
      grey_r  <= grey;
      sv_ok_r <= sat_ok && val_ok;
    end
  end

  always_comb begin
    lo_bound  = HN_W'(cfg.hue_low_max) * HN_W'(d_r);
    hi_bound  = HN_W'(cfg.hue_high_min) * HN_W'(d_r);
    full_turn = HN_W'(d_r) * HN_W'(360);
    hue_ok    = grey_r || (hn_r <= lo_bound) || ((hn_r >= hi_bound) && (hn_r <= full_turn));
    is_red    = hue_ok && sv_ok_r;
  end

endmodule

// ----- src/hsv_red_mask_band_counter_core.sv -----
// Top level of the HSV red mask band counter: register file, occupancy mask
// memory with read-modify-write, band counters. Uses hsvrm_pkg, hsvrm_if,
// hsvrm_classify and the assertion macro header.
//
//   channel  | port   | direction | moves
//   ---------+--------+-----------+--------------------------------------------
//   pixel    | in_pix | sink      | request: rgb, grid cell, frame start
//   result   | out_res| source    | request: red flag, five band counts
//   register | cfg_wr | sink      | request: register index, write data
//
// One pixel per cycle unless results stall; a result passes the middle stage
// and the output register after its pixel is taken. The rate is set by the
// single mask memory: the row is read when the pixel is taken and written
// back as it leaves the middle stage, a last-write register forwarding a row
// written while the next read was in flight. Reset clears per-row valid bits, so
// there is no clearing pass; a frame start clears them alike. A stalled result
// holds in the output register while one more pixel waits in the middle stage.
`include "hsv_red_mask_band_counter_core_macros.svh"

module hsv_red_mask_band_counter_core import hsvrm_pkg::*; #(
  parameter int GRID_WIDTH  = 20,
  parameter int GRID_HEIGHT = 15,
  parameter int BAND_WIDTH  = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  hsvrm_pix_if.sink    in_pix,
  hsvrm_res_if.source  out_res,
  hsvrm_cfg_if.sink    cfg_wr
);

  localparam int ROW_AW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  // register file
  hsvrm_cfg_t cfg_r;

  // middle stage: pixel whose mask row is being read
  logic             s1_vld_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_fs_r;
  logic             s1_red;

  // mask memory, row valid bits and last-write forwarding
  logic [GRID_WIDTH-1:0]  mask_mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0]  mem_rdata_r;
  logic [GRID_HEIGHT-1:0] row_valid_r;
  logic [GRID_HEIGHT-1:0] row_valid_nxt;
  logic                   wr_vld_r;
  logic [ROW_AW-1:0]      wr_row_r;
  logic [GRID_WIDTH-1:0]  wr_data_r;

  // band counters and output register
  logic [COUNT_W-1:0] cnt_r     [NUM_BANDS];
  logic [COUNT_W-1:0] cnt_nxt   [NUM_BANDS];
  logic [COUNT_W-1:0] out_cnt_r [NUM_BANDS];
  logic               out_red_r;
  logic               out_vld_r;

  logic                  in_fire, s1_adv;
  logic [ROW_AW-1:0]     rd_addr, row_idx;
  logic                  in_grid, fwd_hit, mask_wr, cell_new;
  logic [GRID_WIDTH-1:0] bit_mask, row_old, row_new;
  logic [BAND_IDX_W-1:0] band_idx;
  logic [COUNT_W-1:0]    cnt_base;

  // ---------------------------------------------------------------- handshake
  assign s1_adv        = s1_vld_r && (!out_vld_r || out_res.ready);
  assign in_pix.ready  = !s1_vld_r || s1_adv;
  assign in_fire       = in_pix.valid && in_pix.ready;
  assign cfg_wr.ready  = 1'b1;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr.valid) begin
      unique case (hsvrm_reg_t'(cfg_wr.index))
        REG_HUE_LOW_MAX:  cfg_r.hue_low_max  <= cfg_wr.data;
        REG_HUE_HIGH_MIN: cfg_r.hue_high_min <= cfg_wr.data;
        REG_SAT_MIN:      cfg_r.sat_min      <= cfg_wr.data[PCT_W-1:0];
        REG_SAT_MAX:      cfg_r.sat_max      <= cfg_wr.data[PCT_W-1:0];
        REG_VAL_MIN:      cfg_r.val_min      <= cfg_wr.data[PCT_W-1:0];
        REG_VAL_MAX:      cfg_r.val_max      <= cfg_wr.data[PCT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ------------------------------------------------------------ colour test
  hsvrm_classify u_classify (
    .clk    (clk),
    .load   (in_fire),
    .red    (in_pix.red),
    .green  (in_pix.green),
    .blue   (in_pix.blue),
    .cfg    (cfg_r),
    .is_red (s1_red)
  );

  // ------------------------------------------------------------ middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r <= in_pix.col;
      s1_row_r <= in_pix.row;
      s1_fs_r  <= in_pix.frame_start;
    end
  end

  // ------------------------------------------------------------- mask memory
  assign rd_addr = ROW_AW'(in_pix.row);
  assign row_idx = ROW_AW'(s1_row_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rdata_r <= mask_mem[rd_addr];
    end
    if (s1_adv && mask_wr) begin
      mask_mem[row_idx] <= row_new;
    end
  end

  // -------------------------------------------------------- read-modify-write
  always_comb begin
    in_grid  = ({1'b0, s1_col_r} < (COL_W + 1)'(GRID_WIDTH)) &&
               ({3'b000, s1_row_r} < (ROW_W + 3)'(GRID_HEIGHT));
    fwd_hit  = wr_vld_r && (wr_row_r == row_idx);
    // a cleared frame or a row not yet written this frame reads as empty
    if (s1_fs_r || !row_valid_r[row_idx]) begin
      row_old = '0;
    end else if (fwd_hit) begin
      row_old = wr_data_r;
    end else begin
      row_old = mem_rdata_r;
    end
    bit_mask = GRID_WIDTH'(1) << s1_col_r;
    row_new  = row_old | bit_mask;
    mask_wr  = s1_red && in_grid;
    cell_new = mask_wr && ((row_old & bit_mask) == '0);

    // a frame start drops every row, then the written row becomes valid
    row_valid_nxt = s1_fs_r ? '0 : row_valid_r;
    if (mask_wr) begin
      row_valid_nxt[row_idx] = 1'b1;
    end

    // band by threshold compares; columns past the last band land in it
    band_idx = '0;
    for (int k = 1; k < NUM_BANDS; k++) begin
      if ({1'b0, s1_col_r} >= (COL_W + 1)'(k * BAND_WIDTH)) begin
        band_idx = BAND_IDX_W'(k);
      end
    end
    for (int k = 0; k < NUM_BANDS; k++) begin
      cnt_base   = s1_fs_r ? '0 : cnt_r[k];
      cnt_nxt[k] = cnt_base;
      if (cell_new && (band_idx == BAND_IDX_W'(k)) && (cnt_base != COUNT_MAX)) begin
        cnt_nxt[k] = cnt_base + COUNT_W'(1);
      end
    end
  end

  // row valid bits, forwarding register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      wr_vld_r    <= 1'b0;
      for (int k = 0; k < NUM_BANDS; k++) cnt_r[k] <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < NUM_BANDS; k++) cnt_r[k] <= cnt_nxt[k];
      row_valid_r <= row_valid_nxt;
      if (mask_wr) begin
        wr_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && mask_wr) begin
      wr_row_r  <= row_idx;
      wr_data_r <= row_new;
    end
  end

  // ------------------------------------------------------------ output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_red_r <= s1_red;
      for (int k = 0; k < NUM_BANDS; k++) out_cnt_r[k] <= cnt_nxt[k];
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.is_red       = out_red_r;
  assign out_res.band_count_0 = out_cnt_r[0];
  assign out_res.band_count_1 = out_cnt_r[1];
  assign out_res.band_count_2 = out_cnt_r[2];
  assign out_res.band_count_3 = out_cnt_r[3];
  assign out_res.band_count_4 = out_cnt_r[4];

  // -------------------------------------------------------------- assertions
  `HSVRM_ASSERT_IMP(a_stall_only_when_full, !in_pix.ready, s1_vld_r && out_vld_r && !out_res.ready)
  `HSVRM_ASSERT_NXT(a_adv_fills_out, s1_adv, out_vld_r)
  `HSVRM_ASSERT_NXT(a_frame_clears_rows, s1_adv && s1_fs_r, $countones(row_valid_r) <= 1)
  `HSVRM_ASSERT_NXT(a_write_marks_row, s1_adv && mask_wr, wr_vld_r && row_valid_r[wr_row_r])

endmodule

// ----- bench/hsv_red_mask_band_counter_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for hsv_red_mask_band_counter_core: pixel requests, register writes,
// a cycle-free predictor of the red flag and band counts, and per-field result checks.
// Depends on hsvrm_pkg and the channel interfaces of hsvrm_if.

module hsv_red_mask_band_counter_core_test;
  import hsvrm_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int GRID_W       = 20;
  localparam int GRID_H       = 15;
  localparam int BAND_W       = 4;
  localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS  = 80;
  localparam int NUM_PHASES   = 6;
  localparam int RANDOM_PHASE = 4;     // this phase draws its window settings at random
  localparam int NUM_DIRECTED = 23;
  localparam int TAIL_CYCLES  = 8;     // result passes the middle stage and output register after its request

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_start;
  } pixel_req_t;

  typedef struct packed {
    logic                              is_red;
    logic [NUM_BANDS-1:0][COUNT_W-1:0] band_count;
  } band_report_t;

  // One row of the directed table; a typed row carries its expected report.
  typedef struct {
    int red, green, blue, col, row, frame_start;
    bit typed;
    int is_red;
    int counts [NUM_BANDS];
  } directed_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  hsvrm_pix_if pix_ch ();
  hsvrm_res_if res_ch ();
  hsvrm_cfg_if cfg_ch ();

  hsv_red_mask_band_counter_core #(
    .GRID_WIDTH  (GRID_W),
    .GRID_HEIGHT (GRID_H),
    .BAND_WIDTH  (BAND_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_res (res_ch),
    .cfg_wr  (cfg_ch)
  );

  // Bench copy of the block's state: windows, occupancy mask and band counts.
  hsvrm_cfg_t         window_model = CFG_RESET;
  logic [GRID_W-1:0]  mask_model [GRID_H];
  logic [COUNT_W-1:0] band_model [NUM_BANDS];

  band_report_t expected_reports [$];
  bit           typed_pending;
  band_report_t typed_report;
  bit           steady_stretch;

  int mismatches      = 0;
  int pixels_taken    = 0;
  int reports_checked = 0;
  int red_reports     = 0;
  int frames_started  = 0;
  int idle_cycles     = 0;

  // Directed pixels. Columns: r, g, b, col, row, frame_start, typed, is_red, bands 0..4.
  // Typed rows run under the reset windows (hue 0..60 or 300..360, sat 10..100,
  // value 15..90); the rest are left to the predictor.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{  0,   0,   0,  0,  0, 1, 1, 0, '{0, 0, 0, 0, 0}},  // black, new frame: grey fails sat
    '{200,   0,   0,  0,  0, 0, 1, 1, '{1, 0, 0, 0, 0}},  // plain red sets its cell
    '{200,   0,   0,  0,  0, 0, 1, 1, '{1, 0, 0, 0, 0}},  // same cell again: no recount
    '{255,   0,   0,  1,  0, 0, 1, 0, '{1, 0, 0, 0, 0}},  // too bright for value window
    '{  0, 200,   0,  2,  0, 0, 1, 0, '{1, 0, 0, 0, 0}},  // green hue
    '{  0,   0, 200,  3,  0, 0, 1, 0, '{1, 0, 0, 0, 0}},  // blue hue
    '{200,   0, 150, 19, 14, 0, 1, 1, '{1, 0, 0, 0, 1}},  // magenta side, last cell
    '{200,   0,   0, 20,  0, 0, 1, 1, '{1, 0, 0, 0, 1}},  // column off the grid
    '{200,   0,   0, 31, 15, 0, 1, 1, '{1, 0, 0, 0, 1}},  // both off the grid
    '{200,   0,   0,  5, 15, 0, 1, 1, '{1, 0, 0, 0, 1}},  // row off the grid
    '{200,   0,   0,  5,  3, 0, 1, 1, '{1, 1, 0, 0, 1}},  // second band
    '{200,   0,   0,  8,  7, 1, 1, 1, '{0, 0, 1, 0, 0}},  // frame start clears first
    '{255, 255, 255, 12,  2, 0, 1, 0, '{0, 0, 1, 0, 0}},  // white
    '{200, 200,   0, 12,  2, 0, 0, 0, '{0, 0, 0, 0, 0}},  // hue exactly 60
    '{200,   0, 200, 13,  2, 0, 0, 0, '{0, 0, 0, 0, 0}},  // hue exactly 300
    '{100, 200,  50, 16,  9, 0, 0, 0, '{0, 0, 0, 0, 0}},  // green max, blue below red
    '{ 50, 200, 100,  4, 14, 0, 0, 0, '{0, 0, 0, 0, 0}},  // green max, blue above red
    '{100,  50, 200,  9,  0, 0, 0, 0, '{0, 0, 0, 0, 0}},  // blue max, red above green
    '{ 50, 100, 200, 15, 10, 0, 0, 0, '{0, 0, 0, 0, 0}},  // blue max, green above red
    '{  1,   0,   0,  0,  1, 0, 0, 0, '{0, 0, 0, 0, 0}},  // nearly black red
    '{230,  23,  23,  7,  6, 0, 0, 0, '{0, 0, 0, 0, 0}},  // value at the top edge
    '{ 64,   0,  10, 11, 11, 0, 0, 0, '{0, 0, 0, 0, 0}},  // value exactly 25 percent
    '{255, 255, 254,  3, 13, 0, 0, 0, '{0, 0, 0, 0, 0}}   // almost grey
  };

  // Window settings per random phase; the random phase overwrites its entry.
  hsvrm_cfg_t phase_settings [NUM_PHASES] = '{
    '{9'd360, 9'd0,   7'd0,   7'd100, 7'd0,   7'd100},  // everything passes
    '{9'd0,   9'd360, 7'd0,   7'd127, 7'd0,   7'd127},  // hue 0 only, wide sat and value
    '{9'd511, 9'd511, 7'd127, 7'd127, 7'd100, 7'd100},  // all-ones and beyond range
    '{9'd200, 9'd100, 7'd80,  7'd20,  7'd90,  7'd10},   // inverted sat and value windows
    '{9'd60,  9'd300, 7'd10,  7'd100, 7'd15,  7'd90},
    CFG_RESET
  };

  // Classify one pixel against the current windows, then update mask and counts.
  // Every test is an exact cross-multiplication, ties included.
  function automatic band_report_t classify_and_count(input pixel_req_t p);
    int unsigned r, g, b, mx, mn, d, hn, band;
    logic [BAND_IDX_W-1:0] bi;
    bit hue_ok, sat_ok, val_ok;
    band_report_t rep;
    r = 32'(p.red);
    g = 32'(p.green);
    b = 32'(p.blue);
    if (p.frame_start) begin
      foreach (mask_model[i]) mask_model[i] = '0;
      foreach (band_model[i]) band_model[i] = '0;
    end
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    val_ok = (100 * mx >= window_model.val_min * 256) && (100 * mx <= window_model.val_max * 256);
    if (mx == mn) begin
      // grey: hue 0 always passes, saturation 0 needs a zero floor
      hue_ok = 1'b1;
      sat_ok = (window_model.sat_min == 0);
    end else begin
      d = mx - mn;
      // hn is hue times d, kept in [0, 360*d)
      if (mx == r)      hn = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
      else if (mx == g) hn = (b >= r) ? 120 * d + 60 * (b - r) : 120 * d - 60 * (r - b);
      else              hn = (r >= g) ? 240 * d + 60 * (r - g) : 240 * d - 60 * (g - r);
      hue_ok = (hn <= window_model.hue_low_max * d) ||
               (hn >= window_model.hue_high_min * d && hn <= 360 * d);
      sat_ok = (100 * d >= window_model.sat_min * mx) && (100 * d <= window_model.sat_max * mx);
    end
    rep.is_red = hue_ok && sat_ok && val_ok;
    if (rep.is_red && p.col < GRID_W && p.row < GRID_H) begin
      if (!mask_model[p.row][p.col]) begin
        mask_model[p.row][p.col] = 1'b1;
        band = p.col / BAND_W;
        if (band >= NUM_BANDS) band = NUM_BANDS - 1;
        bi = BAND_IDX_W'(band);
        if (band_model[bi] < COUNT_MAX) band_model[bi] = band_model[bi] + 1'b1;
      end
    end
    for (int k = 0; k < NUM_BANDS; k++) rep.band_count[k] = band_model[k];
    return rep;
  endfunction

  // Reddish pixels most often, so that the mask fills; some grey, saturated and arbitrary.
  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    int kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      p.red   = CH_W'($urandom_range(40, 255));
      p.green = CH_W'($urandom_range(0, p.red / 2));
      p.blue  = CH_W'($urandom_range(0, p.red / 2));
    end else if (kind < 55) begin
      p.red   = CH_W'($urandom_range(0, 255));
      p.green = p.red;
      p.blue  = p.red;
    end else if (kind < 62) begin
      p.red   = $urandom_range(1) ? 8'hff : 8'h00;
      p.green = $urandom_range(1) ? 8'hff : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hff : 8'h00;
    end else begin
      p.red   = CH_W'($urandom_range(0, 255));
      p.green = CH_W'($urandom_range(0, 255));
      p.blue  = CH_W'($urandom_range(0, 255));
    end
    p.col = ($urandom_range(99) < 90) ? COL_W'($urandom_range(0, GRID_W - 1))
                                      : COL_W'($urandom_range(GRID_W, 31));
    p.row = ($urandom_range(99) < 92) ? ROW_W'($urandom_range(0, GRID_H - 1)) : 4'd15;
    p.frame_start = ($urandom_range(99) < 3);
    return p;
  endfunction

  // Offer one pixel request, idling first now and then; hold it until taken.
  task automatic send_pixel(input pixel_req_t p, input bit typed, input band_report_t rep);
    @(negedge clk);
    if (!steady_stretch && $urandom_range(99) < 20) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.red         <= p.red;
    pix_ch.green       <= p.green;
    pix_ch.blue        <= p.blue;
    pix_ch.col         <= p.col;
    pix_ch.row         <= p.row;
    pix_ch.frame_start <= p.frame_start;
    typed_pending = typed;
    typed_report  = rep;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Drop the pixel valid and wait until every expected report has come back.
  task automatic drain_reports();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input hsvrm_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_windows(input hsvrm_cfg_t s);
    write_reg(REG_HUE_LOW_MAX,  s.hue_low_max);
    write_reg(REG_HUE_HIGH_MIN, s.hue_high_min);
    write_reg(REG_SAT_MIN,      CFG_DATA_W'(s.sat_min));
    write_reg(REG_SAT_MAX,      CFG_DATA_W'(s.sat_max));
    write_reg(REG_VAL_MIN,      CFG_DATA_W'(s.val_min));
    write_reg(REG_VAL_MAX,      CFG_DATA_W'(s.val_max));
  endtask

  // Result side: stall about one cycle in five, except in the steady stretch.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady_stretch || ($urandom_range(99) >= 20);
    end
  end

  // Observe every handshake at the rising edge: apply register writes to the
  // bench windows, predict on each pixel request, check each report in order.
  always @(posedge clk) begin
    band_report_t got, want;
    pixel_req_t   p;
    bit           any_fire;
    if (rst_n) begin
      any_fire = (cfg_ch.valid && cfg_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
                 (res_ch.valid && res_ch.ready);
      idle_cycles <= any_fire ? 0 : idle_cycles + 1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (hsvrm_reg_t'(cfg_ch.index))
          REG_HUE_LOW_MAX:  window_model.hue_low_max  = cfg_ch.data;
          REG_HUE_HIGH_MIN: window_model.hue_high_min = cfg_ch.data;
          REG_SAT_MIN:      window_model.sat_min      = cfg_ch.data[PCT_W-1:0];
          REG_SAT_MAX:      window_model.sat_max      = cfg_ch.data[PCT_W-1:0];
          REG_VAL_MIN:      window_model.val_min      = cfg_ch.data[PCT_W-1:0];
          REG_VAL_MAX:      window_model.val_max      = cfg_ch.data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        p = '{pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.col, pix_ch.row,
              pix_ch.frame_start};
        want = classify_and_count(p);
        // a typed row stands in for the prediction; the state still advances
        if (typed_pending) want = typed_report;
        expected_reports.push_back(want);
        pixels_taken++;
        if (p.frame_start) frames_started++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.is_red        = res_ch.is_red;
        got.band_count[0] = res_ch.band_count_0;
        got.band_count[1] = res_ch.band_count_1;
        got.band_count[2] = res_ch.band_count_2;
        got.band_count[3] = res_ch.band_count_3;
        got.band_count[4] = res_ch.band_count_4;
        if (expected_reports.size() == 0) begin
          $display("%0t: report with nothing expected, is_red %0d", $time, got.is_red);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (got.is_red === 1'b1) red_reports++;
          if (got.is_red !== want.is_red) begin
            $display("%0t: is_red expected %0d, got %0d", $time, want.is_red, got.is_red);
            mismatches++;
          end
          for (int k = 0; k < NUM_BANDS; k++) begin
            if (got.band_count[k] !== want.band_count[k]) begin
              $display("%0t: band_count_%0d expected %0d, got %0d", $time, k,
                       want.band_count[k], got.band_count[k]);
              mismatches++;
            end
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("hsv_red_mask_band_counter_core_test: errors");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t drow;
    pixel_req_t    p;
    band_report_t  rep;
    // hold every input at a known value from time zero
    pix_ch.valid       = 1'b0;
    pix_ch.red         = '0;
    pix_ch.green       = '0;
    pix_ch.blue        = '0;
    pix_ch.col         = '0;
    pix_ch.row         = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_HUE_LOW_MAX;
    cfg_ch.data        = '0;
    steady_stretch     = 1'b0;
    typed_pending      = 1'b0;
    typed_report       = '0;
    foreach (mask_model[i]) mask_model[i] = '0;
    foreach (band_model[i]) band_model[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part runs under the reset windows
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      drow = directed_rows[i];
      p = '{CH_W'(drow.red), CH_W'(drow.green), CH_W'(drow.blue), COL_W'(drow.col),
            ROW_W'(drow.row), 1'(drow.frame_start)};
      rep.is_red = 1'(drow.is_red);
      for (int k = 0; k < NUM_BANDS; k++) rep.band_count[k] = COUNT_W'(drow.counts[k]);
      send_pixel(p, drow.typed, rep);
    end

    // random phases, each under its own windows, written while the block is idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_reports();
      if (ph == RANDOM_PHASE) begin
        phase_settings[ph].hue_low_max  = HUE_W'($urandom_range(0, 360));
        phase_settings[ph].hue_high_min = HUE_W'($urandom_range(0, 360));
        phase_settings[ph].sat_min      = PCT_W'($urandom_range(0, 40));
        phase_settings[ph].sat_max      = PCT_W'($urandom_range(50, 100));
        phase_settings[ph].val_min      = PCT_W'($urandom_range(0, 40));
        phase_settings[ph].val_max      = PCT_W'($urandom_range(50, 100));
      end
      apply_windows(phase_settings[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // no idling on either side for a stretch of the wide-open phase
        steady_stretch = (ph == 0) && (n >= 20) && (n < 60);
        send_pixel(random_pixel(), 1'b0, '0);
      end
      steady_stretch = 1'b0;
    end

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, expected_reports.size());
      mismatches++;
    end

    $display("Covered %0d pixel requests over %0d frame starts and %0d window settings;",
             pixels_taken, frames_started, NUM_PHASES + 1);
    $display("checked %0d reports, %0d of them red, %0d mismatches.",
             reports_checked, red_reports, mismatches);
    if (mismatches == 0) begin
      $display("hsv_red_mask_band_counter_core_test: clean");
    end else begin
      $display("hsv_red_mask_band_counter_core_test: errors");
    end
    $finish;
  end

endmodule
